// ===== hdl/ckm_pkg.sv =====
// Package for the command keyword matcher.
// Holds field widths, the pattern table, the verdict codes and the link struct.
// No dependencies.
package ckm_pkg;

  localparam int unsigned PatternCount = 8;
  localparam int unsigned PatternSlots = 15;
  localparam int unsigned SymWidth     = 8;
  localparam int unsigned PosWidth     = 4;
  localparam int unsigned VerdictWidth = 2;
  localparam int unsigned IndexWidth   = 4;
  localparam int unsigned MaskWidth    = PatternCount + 1;
  localparam int unsigned OutWidth     = 8;

  localparam logic [PosWidth-1:0]  PosMax    = '1;
  localparam logic [MaskWidth-1:0] MaskReset = '1;
  localparam logic [SymWidth-1:0]  Wildcard  = 8'h2A;

  // Unused tail slots are wildcards; the length check rejects them.
  localparam logic [PatternSlots*SymWidth-1:0] PatternText [PatternCount] = '{
    "GETV***********",
    "FURQ***********",
    "MCPR***********",
    "MLRQ***********",
    "STOP***********",
    "FCRC***********",
    "REST***********",
    "CH*************"
  };

  localparam logic [PosWidth-1:0] PatternLen [PatternCount] = '{
    4'd8, 4'd8, 4'd14, 4'd8, 4'd8, 4'd12, 4'd8, 4'd8
  };

  typedef enum logic [VerdictWidth-1:0] {
    VERDICT_BLANK    = 2'd0,
    VERDICT_ENABLED  = 2'd1,
    VERDICT_DISABLED = 2'd2,
    VERDICT_WRONG    = 2'd3
  } verdict_e;

  typedef struct packed {
    logic                    valid;
    logic [PosWidth-1:0]     pos;
    logic [PatternCount-1:0] alive;
  } line_req_t;

  function automatic logic char_match(input int unsigned k,
                                      input logic [PosWidth-1:0] pos,
                                      input logic [SymWidth-1:0] sym);
    logic [SymWidth-1:0] pc;
    pc = PatternText[k][(PatternSlots-1-32'(pos))*SymWidth +: SymWidth];
    if (pos >= PatternLen[k]) begin
      return 1'b0;
    end
    return (pc == Wildcard) || (pc == sym);
  endfunction

endpackage

// ===== hdl/ckm_line_tracker.sv =====
// Input register and per-line match state for the command keyword matcher.
// Depends on ckm_pkg.
module ckm_line_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [ckm_pkg::SymWidth-1:0] s_symbol_i,
  input  logic                         s_last_i,
  input  logic                         cls_ready_i,
  output ckm_pkg::line_req_t           req_o
);
  import ckm_pkg::*;

  logic                    in_valid_q, in_valid_d;
  logic [SymWidth-1:0]     in_sym_q;
  logic                    in_last_q;
  logic [PosWidth-1:0]     pos_q, pos_d;
  logic [PatternCount-1:0] alive_q, alive_d;
  logic                    advance;

  assign advance   = in_valid_q && (!in_last_q || cls_ready_i);
  assign s_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = s_ready_o ? s_valid_i : in_valid_q;
    pos_d      = pos_q;
    alive_d    = alive_q;
    if (advance) begin
      if (in_last_q) begin
        pos_d   = '0;
        alive_d = '1;
      end else begin
        for (int unsigned k = 0; k < PatternCount; k++) begin
          alive_d[k] = alive_q[k] && char_match(k, pos_q, in_sym_q);
        end
        if (pos_q != PosMax) begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
      alive_q    <= '1;
    end else begin
      in_valid_q <= in_valid_d;
      pos_q      <= pos_d;
      alive_q    <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_sym_q  <= s_symbol_i;
      in_last_q <= s_last_i;
    end
  end

  assign req_o.valid = in_valid_q && in_last_q;
  assign req_o.pos   = pos_q;
  assign req_o.alive = alive_q;

endmodule

// ===== hdl/ckm_classifier.sv =====
// Line classification and result register for the command keyword matcher.
// Holds the enable mask. Depends on ckm_pkg.
module ckm_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ckm_pkg::MaskWidth-1:0]     cfg_wdata_i,
  input  ckm_pkg::line_req_t                req_i,
  output logic                              ready_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [ckm_pkg::VerdictWidth-1:0]  m_verdict_o,
  output logic [ckm_pkg::IndexWidth-1:0]    m_index_o
);
  import ckm_pkg::*;

  logic [MaskWidth-1:0]    mask_q;
  logic                    out_valid_q, out_valid_d;
  verdict_e                verdict_q, verdict_d;
  logic [IndexWidth-1:0]   index_q, index_d;
  logic [PatternCount-1:0] hit;
  logic                    found;

  assign ready_o = !out_valid_q || m_ready_i;

  always_comb begin
    for (int unsigned k = 0; k < PatternCount; k++) begin
      hit[k] = req_i.alive[k] && (req_i.pos == PatternLen[k]);
    end
    found     = 1'b0;
    verdict_d = VERDICT_WRONG;
    index_d   = '0;
    for (int unsigned k = 0; k < PatternCount; k++) begin
      if (hit[k] && !found) begin
        found     = 1'b1;
        index_d   = IndexWidth'(k + 1);
        verdict_d = mask_q[k] ? VERDICT_ENABLED : VERDICT_DISABLED;
      end
    end
    if (!found && req_i.pos == '0) begin
      verdict_d = mask_q[PatternCount] ? VERDICT_BLANK : VERDICT_DISABLED;
    end
    out_valid_d = ready_o ? req_i.valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= MaskReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && ready_o) begin
      verdict_q <= verdict_d;
      index_q   <= index_d;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign m_verdict_o = verdict_q;
  assign m_index_o   = index_q;

endmodule

// ===== hdl/command_keyword_matcher_core.sv =====
// Top level of the command keyword matcher.
// Instantiates ckm_line_tracker and ckm_classifier; depends on ckm_pkg.
//
// Usage:
//   Slave stream carries one character per word: tdata is the symbol,
//   tlast marks the line terminator (its tdata is ignored). The master
//   stream gives one result word per terminator; character words give none.
//   cfg_we_i writes the 9-bit command enable mask (bits 0-7 commands 1-8,
//   bit 8 blank); write it only while no line result is pending.
// Path: an accepted terminator waits in the input register, then its result is captured in the output register.
// Throughput: one word per cycle while no terminator waits on a held result. Each word is registered
//   on entry, all eight patterns are compared in parallel against it, and the
//   line result lands in a single output register.
// Reset: clears the line state (position 0, all patterns alive), sets the
//   enable mask to all ones and empties both registers.
// Stall: while m_axis_tready is low a held result blocks only the next
//   terminator; characters keep flowing until a terminator reaches the input
//   register, which then holds and drops s_axis_tready.
module command_keyword_matcher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] symbol
  input  logic                          s_axis_tlast,  // line_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [1:0] verdict, [5:2] command_index
  input  logic                          cfg_we_i,
  input  logic [ckm_pkg::MaskWidth-1:0] cfg_wdata_i
);
  import ckm_pkg::*;

  line_req_t               req;
  logic                    cls_ready;
  logic [VerdictWidth-1:0] verdict;
  logic [IndexWidth-1:0]   index;

  ckm_line_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_symbol_i  (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .cls_ready_i (cls_ready),
    .req_o       (req)
  );

  ckm_classifier u_classifier (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .ready_o     (cls_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_verdict_o (verdict),
    .m_index_o   (index)
  );

  assign m_axis_tdata = {{(OutWidth-VerdictWidth-IndexWidth){1'b0}}, index, verdict};

endmodule

// ===== verif/tb_command_keyword_matcher_core.sv =====
// Testbench for command_keyword_matcher_core: streams command lines with random gaps,
// tracks expected verdicts in a scoreboard class and checks every result word.
// Depends on ckm_pkg and the command_keyword_matcher_core RTL.
module tb_command_keyword_matcher_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ckm_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseWords = 175;
  localparam int unsigned LongHold   = 300;

  // keyword heads, upper byte first; '*' marks a free position
  localparam logic [31:0] CmdPrefix [8] = '{
    "GETV", "FURQ", "MCPR", "MLRQ", "STOP", "FCRC", "REST", "CH**"
  };
  localparam int CmdLength [8] = '{8, 8, 14, 8, 8, 12, 8, 8};

  typedef logic [7:0] line_t [$];

  class line_scoreboard;
    logic [MaskWidth-1:0] enable_mask;
    logic [3:0]           position;
    logic [7:0]           alive;
    verdict_e             verdict_q [$];
    logic [3:0]           index_q [$];
    int unsigned          errors;

    function new();
      enable_mask = '1;
      position    = '0;
      alive       = '1;
      errors      = 0;
    endfunction

    function void set_mask(logic [MaskWidth-1:0] value);
      enable_mask = value;
    endfunction

    function int unsigned waiting();
      return verdict_q.size();
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void note_word(logic [7:0] sym, logic last);
      verdict_e   v;
      logic [3:0] idx;
      logic [7:0] pc;
      int         p;
      p = position;
      if (!last) begin
        for (int k = 0; k < 8; k++) begin
          pc = (p < 4) ? CmdPrefix[k][8*(3-p) +: 8] : Wildcard;
          if (p >= CmdLength[k] || (pc != Wildcard && pc != sym)) alive[k] = 1'b0;
        end
        if (position != 4'hF) position++;
        return;
      end
      v   = VERDICT_WRONG;
      idx = '0;
      for (int k = 0; k < 8; k++) begin
        if (alive[k] && p == CmdLength[k]) begin
          idx = 4'(k + 1);
          v   = enable_mask[k] ? VERDICT_ENABLED : VERDICT_DISABLED;
          break;
        end
      end
      if (idx == 0 && p == 0) v = enable_mask[8] ? VERDICT_BLANK : VERDICT_DISABLED;
      verdict_q.push_back(v);
      index_q.push_back(idx);
      position = '0;
      alive    = '1;
    endfunction

    function void check_result(logic [1:0] verdict, logic [3:0] index);
      verdict_e   v;
      logic [3:0] idx;
      if (verdict_q.size() == 0) begin
        flag($sformatf("unexpected result verdict=%0d index=%0d", verdict, index));
        return;
      end
      v   = verdict_q.pop_front();
      idx = index_q.pop_front();
      if (verdict !== v)
        flag($sformatf("verdict expected %s got %0d", v.name(), verdict));
      if (index !== idx)
        flag($sformatf("command_index expected %0d got %0d", idx, index));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we_i;
  logic [MaskWidth-1:0] cfg_wdata_i;

  line_scoreboard board;
  int unsigned    cycle_count;
  int unsigned    words_sent;
  bit             tx_gappy;
  bit             long_hold_pending;

  command_keyword_matcher_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] wild_char();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic line_t make_line();
    line_t chars;
    int    roll, k, n;
    logic [7:0] pc;
    roll = $urandom_range(0, 99);
    k    = $urandom_range(0, 7);
    if (roll < 78) begin
      for (int p = 0; p < CmdLength[k]; p++) begin
        pc = (p < 4) ? CmdPrefix[k][8*(3-p) +: 8] : Wildcard;
        chars.push_back((pc == Wildcard) ? wild_char() : pc);
      end
      if (roll >= 55 && roll < 70) begin
        chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (roll >= 70) begin
        if ($urandom_range(0, 1)) chars.pop_back();
        else chars.push_back(wild_char());
      end
    end else if (roll >= 83) begin
      n = (roll < 90) ? $urandom_range(15, 20) : $urandom_range(1, 14);
      for (int i = 0; i < n; i++) chars.push_back(wild_char());
      if (n < 15 && $urandom_range(0, 1)) chars[0] = CmdPrefix[k][31:24];
    end
    return chars;
  endfunction

  task automatic send_word(input logic [7:0] sym, input logic last);
    int unsigned gap;
    gap = (tx_gappy && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(sym, last);
    words_sent++;
  endtask

  task automatic send_line(input line_t chars);
    tx_gappy = ($urandom_range(0, 3) != 0);
    foreach (chars[i]) send_word(chars[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic settle(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [MaskWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_mask(value);
  endtask

  // result side: check accepted words, stall at random, honor long hold requests
  initial begin
    int unsigned hold_left;
    int unsigned rx_cycles;
    bit          rx_gappy;
    hold_left     = 0;
    rx_cycles     = 0;
    rx_gappy      = 1'b1;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata[1:0], m_axis_tdata[5:2]);
      rx_cycles++;
      if (rx_cycles % 64 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
      if (hold_left == 0 && long_hold_pending) begin
        hold_left         = LongHold;
        long_hold_pending = 1'b0;
      end else if (hold_left == 0 && rx_gappy && $urandom_range(0, 3) == 0) begin
        hold_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    line_t                chars;
    logic [MaskWidth-1:0] mask_plan [7];
    int unsigned          phase_start;
    rst_ni            = 1'b0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    s_axis_tlast      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    cycle_count       = 0;
    words_sent        = 0;
    tx_gappy          = 1'b0;
    long_hold_pending = 1'b0;
    board             = new();
    mask_plan = '{9'h1FF, 9'h000, 9'h0FF, 9'h100, 9'h1FF, 9'h000, 9'h1FF};
    mask_plan[4] = 9'($urandom_range(0, 511));
    mask_plan[5] = 9'($urandom_range(0, 511));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        settle(4);
        write_mask(mask_plan[ph]);
      end
      if (ph == 0) begin
        chars = '{};
        send_line(chars);
        chars = '{"G", "E", "T", "V", 8'h00, 8'hFF, "*", 8'h7F};
        send_line(chars);
        chars = '{"G", "E", "T", "V"};
        repeat (11) chars.push_back("*");
        send_line(chars);
      end else if (ph == 1) begin
        chars = '{};
        send_line(chars);
        chars = '{"C", "H", 8'h00, 8'h80, 8'hFF, 8'h01, 8'h55, 8'hAA};
        send_line(chars);
      end
      if (ph == 1 || ph == 4) long_hold_pending = 1'b1;
      phase_start = words_sent;
      while (words_sent - phase_start < PhaseWords) send_line(make_line());
    end

    settle(8);
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
